// ----- sv/tbn_pkg.sv -----
package tbn_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DELTA_W     = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DELTA_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int MAG_W       = ACC_W - 1;
  localparam int NORM_W      = 31;
  localparam int SUMSQ_W     = 64;
  localparam int LEN_W       = 32;
  localparam int OUT_W       = 16;
  localparam int FRAC_BITS   = 14;
  localparam int QUO_W       = 17;
  localparam int NUM_W       = NORM_W + FRAC_BITS + 1;
  localparam int SQRT_STEPS  = 32;
  localparam int MUL_STEPS   = 14;
  localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic                      compute;
    logic signed [DELTA_W-1:0] du1;
    logic signed [DELTA_W-1:0] dv1;
    logic signed [DELTA_W-1:0] du2;
    logic signed [DELTA_W-1:0] dv2;
    logic signed [DELTA_W-1:0] e1x;
    logic signed [DELTA_W-1:0] e1y;
    logic signed [DELTA_W-1:0] e1z;
    logic signed [DELTA_W-1:0] e2x;
    logic signed [DELTA_W-1:0] e2y;
    logic signed [DELTA_W-1:0] e2z;
  } tbn_cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_ABS,
    B_SHIFT,
    B_SQ,
    B_SQRT,
    B_DIVI,
    B_DIV,
    B_EMIT
  } tbn_back_state_t;

endpackage

// ----- sv/tbn_queue.sv -----
module tbn_queue
  import tbn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tbn_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output tbn_cmd_t head
);

  tbn_cmd_t   mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

// ----- sv/tbn_front.sv -----
module tbn_front
  import tbn_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] tex_u,
  input  logic signed [COORD_WIDTH-1:0] tex_v,
  input  logic                          face_end,
  output logic                          push,
  output tbn_cmd_t                      push_cmd
);

  logic [1:0]                    corner_count;
  logic signed [COORD_WIDTH-1:0] p0x, p0y, p0z, t0u, t0v;
  logic signed [COORD_WIDTH-1:0] p1x, p1y, p1z, t1u, t1v;

  function automatic logic signed [DELTA_W-1:0] dlt(logic signed [COORD_WIDTH-1:0] a,
                                                     logic signed [COORD_WIDTH-1:0] b);
    dlt = DELTA_W'(a) - DELTA_W'(b);
  endfunction

  assign push = accept && corner_count[1];

  always_comb begin
    push_cmd.compute = (corner_count == 2'd2);
    push_cmd.du1 = dlt(t1u, t0u);
    push_cmd.dv1 = dlt(t1v, t0v);
    push_cmd.du2 = dlt(tex_u, t0u);
    push_cmd.dv2 = dlt(tex_v, t0v);
    push_cmd.e1x = dlt(p1x, p0x);
    push_cmd.e1y = dlt(p1y, p0y);
    push_cmd.e1z = dlt(p1z, p0z);
    push_cmd.e2x = dlt(pos_x, p0x);
    push_cmd.e2y = dlt(pos_y, p0y);
    push_cmd.e2z = dlt(pos_z, p0z);
  end

  always_ff @(posedge clk) begin
    if (accept && corner_count == 2'd0) begin
      p0x <= pos_x; p0y <= pos_y; p0z <= pos_z; t0u <= tex_u; t0v <= tex_v;
    end
    if (accept && corner_count == 2'd1) begin
      p1x <= pos_x; p1y <= pos_y; p1z <= pos_z; t1u <= tex_u; t1v <= tex_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (accept) begin
      if (face_end) corner_count <= 2'd0;
      else if (corner_count != 2'd3) corner_count <= corner_count + 2'd1;
    end
  end

endmodule

// ----- sv/tbn_back.sv -----
module tbn_back
  import tbn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  tbn_cmd_t                q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] tangent_x,
  output logic signed [OUT_W-1:0] tangent_y,
  output logic signed [OUT_W-1:0] tangent_z,
  output logic signed [OUT_W-1:0] bitangent_x,
  output logic signed [OUT_W-1:0] bitangent_y,
  output logic signed [OUT_W-1:0] bitangent_z,
  output logic                    degenerate,
  output logic                    run_last
);

  tbn_back_state_t state, state_next;

  tbn_cmd_t                  cmd;
  logic [3:0]                mstep;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   det;
  logic signed [ACC_W-1:0]   tv [3];
  logic signed [ACC_W-1:0]   bv [3];
  logic                      vsel;
  logic [MAG_W-1:0]          mag [3];
  logic [1:0]                idx;
  logic [SUMSQ_W-1:0]        sumsq;
  logic [SUMSQ_W-1:0]        sn;
  logic [SUMSQ_W-1:0]        sr;
  logic [SUMSQ_W-1:0]        sbit;
  logic [4:0]                cnt;
  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          rem;
  logic [QUO_W-1:0]          nlo;
  logic [QUO_W-1:0]          quo;
  logic signed [OUT_W-1:0]   ft [3];
  logic signed [OUT_W-1:0]   fb [3];
  logic                      fdeg;
  logic [1:0]                left;

  logic signed [DELTA_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   term, sum;
  logic [2:0]                qsel;
  logic                      neg;
  logic signed [ACC_W-1:0]   vcur [3];
  logic [MAG_W-1:0]          absv [3];
  logic [MAG_W-1:0]          mmax;
  logic [SUMSQ_W-1:0]        rb;
  logic                      sq_ge;
  logic [NUM_W-1:0]          num;
  logic [LEN_W:0]            dt;
  logic                      dge;
  logic [QUO_W-1:0]          qf;
  logic [QUO_W-1:0]          qc;
  logic signed [OUT_W-1:0]   qs;
  logic                      ld;

  always_comb begin
    case (mstep)
      4'd0:    begin op_a = cmd.du1; op_b = cmd.dv2; end
      4'd1:    begin op_a = cmd.dv1; op_b = cmd.du2; end
      4'd2:    begin op_a = cmd.dv2; op_b = cmd.e1x; end
      4'd3:    begin op_a = cmd.dv1; op_b = cmd.e2x; end
      4'd4:    begin op_a = cmd.du1; op_b = cmd.e2x; end
      4'd5:    begin op_a = cmd.du2; op_b = cmd.e1x; end
      4'd6:    begin op_a = cmd.dv2; op_b = cmd.e1y; end
      4'd7:    begin op_a = cmd.dv1; op_b = cmd.e2y; end
      4'd8:    begin op_a = cmd.du1; op_b = cmd.e2y; end
      4'd9:    begin op_a = cmd.du2; op_b = cmd.e1y; end
      4'd10:   begin op_a = cmd.dv2; op_b = cmd.e1z; end
      4'd11:   begin op_a = cmd.dv1; op_b = cmd.e2z; end
      4'd12:   begin op_a = cmd.du1; op_b = cmd.e2z; end
      default: begin op_a = cmd.du2; op_b = cmd.e1z; end
    endcase
    qsel = mstep[3:1];
    prod = op_a * op_b;
    // after the determinant, flip signs when it is negative
    neg  = mstep[0] ^ ((qsel != 3'd0) && det[ACC_W-1]);
    term = neg ? -ACC_W'(prod) : ACC_W'(prod);
    sum  = (mstep[0] ? acc : '0) + term;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vcur[i] = vsel ? bv[i] : tv[i];
      absv[i] = vcur[i][ACC_W-1] ? MAG_W'(-vcur[i]) : MAG_W'(vcur[i]);
    end
    mmax = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    rb    = sr + sbit;
    sq_ge = (sn >= rb);
    num = {mag[idx][NORM_W-1:0], FRAC_BITS'(0)} + NUM_W'(len >> 1);
    dt  = {rem, nlo[QUO_W-1]};
    dge = (dt >= {1'b0, len});
    qf  = {quo[QUO_W-2:0], dge};
    qc  = (qf > ONE_Q14) ? ONE_Q14 : qf;
    qs  = vcur[idx][ACC_W-1] ? -OUT_W'(qc) : OUT_W'(qc);
    ld  = !out_valid || !out_stall;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_head.compute ? B_MUL : B_EMIT;
        end
      end
      B_MUL: begin
        if (mstep == 4'(MUL_STEPS - 1)) begin
          state_next = (det == '0) ? B_EMIT : B_ABS;
        end
      end
      B_ABS: begin
        state_next = B_SHIFT;
      end
      B_SHIFT: begin
        if (mmax == '0) state_next = B_EMIT;
        else if (mmax[MAG_W-1:NORM_W] == '0 && mmax[NORM_W-1]) state_next = B_SQ;
      end
      B_SQ: begin
        if (idx == 2'd2) state_next = B_SQRT;
      end
      B_SQRT: begin
        if (cnt == 5'(SQRT_STEPS - 1)) state_next = B_DIVI;
      end
      B_DIVI: begin
        state_next = B_DIV;
      end
      B_DIV: begin
        if (cnt == 5'(QUO_W - 1)) begin
          if (idx != 2'd2) state_next = B_DIVI;
          else if (!vsel) state_next = B_ABS;
          else state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (ld && left == 2'd1) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left      <= 2'd0;
      fdeg      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ft[i] <= '0;
        fb[i] <= '0;
      end
    end else begin
      if (state == B_EMIT && ld) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_head;
            mstep <= '0;
            left  <= q_head.compute ? 2'd3 : 2'd1;
          end
        end
        B_MUL: begin
          acc   <= sum;
          mstep <= mstep + 4'd1;
          if (mstep[0]) begin
            if (qsel == 3'd0) det <= sum;
            else if (!qsel[0]) bv[2'((qsel - 3'd1) >> 1)] <= sum;
            else tv[2'((qsel - 3'd1) >> 1)] <= sum;
          end
          if (mstep == 4'(MUL_STEPS - 1)) begin
            vsel <= 1'b0;
            fdeg <= (det == '0);
            if (det == '0) begin
              for (int i = 0; i < 3; i++) begin
                ft[i] <= '0;
                fb[i] <= '0;
              end
            end
          end
        end
        B_ABS: begin
          for (int i = 0; i < 3; i++) mag[i] <= absv[i];
        end
        B_SHIFT: begin
          idx   <= 2'd0;
          sumsq <= '0;
          if (mmax == '0) begin
            fdeg <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              ft[i] <= '0;
              fb[i] <= '0;
            end
          end else if (mmax[MAG_W-1:NORM_W] != '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!mmax[NORM_W-1]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end
        end
        B_SQ: begin
          // one 31x31 square a cycle
          if (idx == 2'd2) begin
            sn   <= sumsq + SUMSQ_W'(mag[idx][NORM_W-1:0] * mag[idx][NORM_W-1:0]);
            sr   <= '0;
            sbit <= SUMSQ_W'(1) << (SUMSQ_W - 2);
            cnt  <= '0;
          end else begin
            sumsq <= sumsq + SUMSQ_W'(mag[idx][NORM_W-1:0] * mag[idx][NORM_W-1:0]);
          end
          idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        B_SQRT: begin
          if (sq_ge) begin
            sn <= sn - rb;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'(SQRT_STEPS - 1)) begin
            len <= sq_ge ? LEN_W'((sr >> 1) + sbit) : LEN_W'(sr >> 1);
            idx <= 2'd0;
          end
        end
        B_DIVI: begin
          rem <= LEN_W'(num[NUM_W-1:QUO_W]);
          nlo <= num[QUO_W-1:0];
          quo <= '0;
          cnt <= '0;
        end
        B_DIV: begin
          rem <= dge ? LEN_W'(dt - {1'b0, len}) : LEN_W'(dt);
          nlo <= nlo << 1;
          quo <= qf;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QUO_W - 1)) begin
            if (vsel) fb[idx] <= qs;
            else ft[idx] <= qs;
            idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
            if (idx == 2'd2) vsel <= 1'b1;
          end
        end
        B_EMIT: begin
          if (ld) begin
            tangent_x   <= ft[0];
            tangent_y   <= ft[1];
            tangent_z   <= ft[2];
            bitangent_x <= fb[0];
            bitangent_y <= fb[1];
            bitangent_z <= fb[2];
            degenerate  <= fdeg;
            run_last    <= (left == 2'd1);
            left        <= left - 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/triangle_tangent_bitangent_core.sv -----
// Per-triangle tangent and bitangent from texture coordinates. Vertices enter one per cycle
// while the queue is not full, into a front stage that keeps the first two corners of a face
// and queues a command (two entries deep) for every vertex from the third on. For the third
// vertex of a face the back stage pops the queue and forms the determinant and both vectors on
// one shared 17x17 multiplier, then per vector takes magnitudes, normalizes them by one-bit
// shifts, sums their squares, takes a bit-by-bit square root and divides each component
// bit-serially before its three words appear; a degenerate face skips the rest once detected.
// Each later vertex gives one word. The first two vertices of a face give nothing. Results
// leave through a registered output, one word a cycle while out_stall is low.
module triangle_tangent_bitangent_core
  import tbn_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] tex_u,
  input  logic signed [COORD_WIDTH-1:0] tex_v,
  input  logic                          face_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_W-1:0]       tangent_x,
  output logic signed [OUT_W-1:0]       tangent_y,
  output logic signed [OUT_W-1:0]       tangent_z,
  output logic signed [OUT_W-1:0]       bitangent_x,
  output logic signed [OUT_W-1:0]       bitangent_y,
  output logic signed [OUT_W-1:0]       bitangent_z,
  output logic                          degenerate,
  output logic                          run_last
);

  logic     accept;
  logic     push;
  tbn_cmd_t push_cmd;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  tbn_cmd_t q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  tbn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .tex_u    (tex_u),
    .tex_v    (tex_v),
    .face_end (face_end),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tbn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  tbn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tangent_x   (tangent_x),
    .tangent_y   (tangent_y),
    .tangent_z   (tangent_z),
    .bitangent_x (bitangent_x),
    .bitangent_y (bitangent_y),
    .bitangent_z (bitangent_z),
    .degenerate  (degenerate),
    .run_last    (run_last)
  );

endmodule
